>>> rtl/core/mtbt_pkg.sv
`timescale 1ns / 1ps

package mtbt_pkg;

    // Byte codes the parser reacts to
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // Field widths of an output word
    localparam int OFS_W   = 13;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Record kinds
    localparam logic KIND_TAG = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Everything one byte produces: an optional tag record, then an optional end record
    typedef struct packed {
        logic               tag_valid;
        logic [INDEX_W-1:0] tag_index;
        logic [OFS_W-1:0]   key_offset;
        logic [OFS_W-1:0]   key_length;
        logic               has_value;
        logic [OFS_W-1:0]   value_offset;
        logic [OFS_W-1:0]   value_length;
        logic               end_valid;
        logic [COUNT_W-1:0] tag_count;
        logic [OFS_W-1:0]   rest_offset;
    } t_bundle;

    // Queue head status seen by the back end
    typedef struct packed {
        logic not_empty;
    } t_qhead_ctl;

endpackage

>>> rtl/core/message_tag_block_tokenizer.sv
`timescale 1ns / 1ps

// Message tag block tokenizer.
// Input channel (i_valid / o_ready): one line byte per word, i_first marks the
// first byte after the '@'. Output channel (o_valid / i_ready): tag records
// (key and value offsets and lengths) and one end record per block carrying
// the tag count and the offset of the rest of the line; o_last flags the last
// word produced by a byte.
// Throughput: one byte per cycle while the queue is not full. A byte that
// yields both a tag and an end record takes two output words, tag first.
// A record passes from its byte through the queue into the output register.
// The front end parses in the accept cycle and writes a four-entry queue; the
// back end drains that queue into the output register.
// Reset: parser waits for a start byte, queue and output register are empty.
// When the receiver stalls, the output word holds, the queue fills, and
// o_ready drops once four bytes with pending records are queued. Bytes that
// produce no record never enter the queue.

module message_tag_block_tokenizer #(
    parameter int MAX_TAGS   = 16,
    parameter int LINE_BYTES = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_byte_value,
    input  logic                          i_first,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_record_kind,
    output logic [mtbt_pkg::INDEX_W-1:0]  o_tag_index,
    output logic [mtbt_pkg::OFS_W-1:0]    o_key_offset,
    output logic [mtbt_pkg::OFS_W-1:0]    o_key_length,
    output logic                          o_has_value,
    output logic [mtbt_pkg::OFS_W-1:0]    o_value_offset,
    output logic [mtbt_pkg::OFS_W-1:0]    o_value_length,
    output logic [mtbt_pkg::COUNT_W-1:0]  o_tag_count,
    output logic [mtbt_pkg::OFS_W-1:0]    o_rest_offset,
    output logic                          o_last
);

    logic                 q_full;
    logic                 push;
    logic                 pop;
    mtbt_pkg::t_bundle    bundle;
    mtbt_pkg::t_bundle    head;
    mtbt_pkg::t_qhead_ctl qctl;

    assign o_ready = !q_full;

    mtbt_front #(
        .MAX_TAGS   (MAX_TAGS),
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid && !q_full),
        .i_byte_value (i_byte_value),
        .i_first      (i_first),
        .o_push       (push),
        .o_bundle     (bundle)
    );

    mtbt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_full   (q_full),
        .o_head   (head),
        .o_ctl    (qctl),
        .i_pop    (pop)
    );

    mtbt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_ctl          (qctl),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_kind  (o_record_kind),
        .o_tag_index    (o_tag_index),
        .o_key_offset   (o_key_offset),
        .o_key_length   (o_key_length),
        .o_has_value    (o_has_value),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length),
        .o_tag_count    (o_tag_count),
        .o_rest_offset  (o_rest_offset),
        .o_last         (o_last)
    );

endmodule

>>> rtl/core/mtbt_front.sv
`timescale 1ns / 1ps

module mtbt_front #(
    parameter int MAX_TAGS   = 16,
    parameter int LINE_BYTES = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte_value,
    input  logic                 i_first,
    output logic                 o_push,
    output mtbt_pkg::t_bundle    o_bundle
);

    localparam int PW = $clog2(LINE_BYTES);
    localparam int SW = $clog2(MAX_TAGS + 1);
    localparam logic [PW-1:0] POS_MAX   = PW'(LINE_BYTES - 1);
    localparam logic [SW-1:0] STORE_MAX = SW'(MAX_TAGS);

    typedef enum logic [1:0] {
        MODE_DONE,
        MODE_KEY,
        MODE_VALUE,
        MODE_SKIP
    } t_mode;

    t_mode         r_mode,   n_mode,   e_mode;
    logic [PW-1:0] r_pos,    n_pos,    e_pos;
    logic [PW-1:0] r_seg,    n_seg,    e_seg;
    logic [PW-1:0] r_klc,    n_klc,    e_klc;
    logic [PW-1:0] r_vst,    n_vst,    e_vst;
    logic          r_vseen,  n_vseen,  e_vseen;
    logic [SW-1:0] r_stored, n_stored, e_stored;

    logic [PW-1:0] pos_next;
    logic [PW-1:0] klen;
    logic          can_store;
    logic          close_tag;
    logic          emit_end;
    logic          tag_valid;

    // State as seen by this word: a start flag restarts the parser at offset 0
    always_comb begin
        if (i_valid && i_first) begin
            e_mode   = MODE_KEY;
            e_pos    = '0;
            e_seg    = '0;
            e_klc    = '0;
            e_vst    = '0;
            e_vseen  = 1'b0;
            e_stored = '0;
        end else begin
            e_mode   = r_mode;
            e_pos    = r_pos;
            e_seg    = r_seg;
            e_klc    = r_klc;
            e_vst    = r_vst;
            e_vseen  = r_vseen;
            e_stored = r_stored;
        end
    end

    // Classify the byte and update the parse state
    always_comb begin
        pos_next  = (e_pos >= POS_MAX) ? POS_MAX : e_pos + PW'(1);
        klen      = e_vseen ? e_klc : e_pos - e_seg;
        can_store = (klen != '0) && (e_stored < STORE_MAX);
        close_tag = 1'b0;
        emit_end  = 1'b0;
        n_mode    = e_mode;
        n_pos     = e_pos;
        n_seg     = e_seg;
        n_klc     = e_klc;
        n_vst     = e_vst;
        n_vseen   = e_vseen;
        if (i_valid && e_mode != MODE_DONE) begin
            n_pos = pos_next;
            case (e_mode)
                MODE_SKIP: begin
                    if (i_byte_value != mtbt_pkg::CHAR_SPACE) begin
                        emit_end = 1'b1;
                        n_mode   = MODE_DONE;
                    end
                end
                default: begin
                    if (i_byte_value == mtbt_pkg::CHAR_NUL) begin
                        close_tag = 1'b1;
                        emit_end  = 1'b1;
                        n_mode    = MODE_DONE;
                    end else if (i_byte_value == mtbt_pkg::CHAR_SPACE) begin
                        close_tag = 1'b1;
                        n_mode    = MODE_SKIP;
                    end else if (i_byte_value == mtbt_pkg::CHAR_SEMI) begin
                        close_tag = 1'b1;
                        n_mode    = MODE_KEY;
                        n_seg     = pos_next;
                        n_klc     = '0;
                        n_vst     = '0;
                        n_vseen   = 1'b0;
                    end else if (i_byte_value == mtbt_pkg::CHAR_EQ && e_mode == MODE_KEY) begin
                        n_klc   = e_pos - e_seg;
                        n_vst   = pos_next;
                        n_vseen = 1'b1;
                        n_mode  = MODE_VALUE;
                    end
                end
            endcase
        end
        tag_valid = close_tag && can_store;
        n_stored  = e_stored + SW'(tag_valid);
    end

    // Records for the queue
    always_comb begin
        o_push                = tag_valid || emit_end;
        o_bundle.tag_valid    = tag_valid;
        o_bundle.tag_index    = mtbt_pkg::INDEX_W'(e_stored);
        o_bundle.key_offset   = mtbt_pkg::OFS_W'(e_seg);
        o_bundle.key_length   = mtbt_pkg::OFS_W'(klen);
        o_bundle.has_value    = e_vseen;
        o_bundle.value_offset = e_vseen ? mtbt_pkg::OFS_W'(e_vst) : '0;
        o_bundle.value_length = e_vseen ? mtbt_pkg::OFS_W'(e_pos - e_vst) : '0;
        o_bundle.end_valid    = emit_end;
        o_bundle.tag_count    = mtbt_pkg::COUNT_W'(n_stored);
        o_bundle.rest_offset  = mtbt_pkg::OFS_W'(e_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DONE;
            r_pos    <= '0;
            r_seg    <= '0;
            r_klc    <= '0;
            r_vst    <= '0;
            r_vseen  <= 1'b0;
            r_stored <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_seg    <= n_seg;
            r_klc    <= n_klc;
            r_vst    <= n_vst;
            r_vseen  <= n_vseen;
            r_stored <= n_stored;
        end
    end

endmodule

>>> rtl/core/mtbt_queue.sv
`timescale 1ns / 1ps

module mtbt_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mtbt_pkg::t_bundle      i_bundle,
    output logic                   o_full,
    output mtbt_pkg::t_bundle      o_head,
    output mtbt_pkg::t_qhead_ctl   o_ctl,
    input  logic                   i_pop
);

    mtbt_pkg::t_bundle r_mem [mtbt_pkg::QUEUE_DEPTH];

    logic [mtbt_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mtbt_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mtbt_pkg::QCNT_W-1:0] r_count,  n_count;

    // Pointer and fill count updates
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + mtbt_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + mtbt_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + mtbt_pkg::QCNT_W'(i_push) - mtbt_pkg::QCNT_W'(i_pop);
    end

    assign o_full        = (r_count == mtbt_pkg::QCNT_W'(mtbt_pkg::QUEUE_DEPTH));
    assign o_ctl.not_empty = (r_count != '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/core/mtbt_back.sv
`timescale 1ns / 1ps

module mtbt_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtbt_pkg::t_bundle                   i_head,
    input  mtbt_pkg::t_qhead_ctl                i_ctl,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_record_kind,
    output logic [mtbt_pkg::INDEX_W-1:0]        o_tag_index,
    output logic [mtbt_pkg::OFS_W-1:0]          o_key_offset,
    output logic [mtbt_pkg::OFS_W-1:0]          o_key_length,
    output logic                                o_has_value,
    output logic [mtbt_pkg::OFS_W-1:0]          o_value_offset,
    output logic [mtbt_pkg::OFS_W-1:0]          o_value_length,
    output logic [mtbt_pkg::COUNT_W-1:0]        o_tag_count,
    output logic [mtbt_pkg::OFS_W-1:0]          o_rest_offset,
    output logic                                o_last
);

    logic r_valid;
    logic r_tag_done;
    logic out_free;
    logic send_tag;
    logic send_end;

    // Tag record goes first; the end record of the same byte follows
    always_comb begin
        out_free = !r_valid || i_ready;
        send_tag = out_free && i_ctl.not_empty && i_head.tag_valid && !r_tag_done;
        send_end = out_free && i_ctl.not_empty && !send_tag;
        o_pop    = send_end || (send_tag && !i_head.end_valid);
    end

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_tag_done <= 1'b0;
        end else begin
            if (send_tag || send_end) begin
                r_valid <= 1'b1;
            end else if (out_free) begin
                r_valid <= 1'b0;
            end
            if (send_tag && i_head.end_valid) begin
                r_tag_done <= 1'b1;
            end else if (send_end) begin
                r_tag_done <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (send_tag) begin
            o_record_kind  <= mtbt_pkg::KIND_TAG;
            o_tag_index    <= i_head.tag_index;
            o_key_offset   <= i_head.key_offset;
            o_key_length   <= i_head.key_length;
            o_has_value    <= i_head.has_value;
            o_value_offset <= i_head.value_offset;
            o_value_length <= i_head.value_length;
            o_tag_count    <= '0;
            o_rest_offset  <= '0;
            o_last         <= !i_head.end_valid;
        end else if (send_end) begin
            o_record_kind  <= mtbt_pkg::KIND_END;
            o_tag_index    <= '0;
            o_key_offset   <= '0;
            o_key_length   <= '0;
            o_has_value    <= 1'b0;
            o_value_offset <= '0;
            o_value_length <= '0;
            o_tag_count    <= i_head.tag_count;
            o_rest_offset  <= i_head.rest_offset;
            o_last         <= 1'b1;
        end
    end

endmodule

>>> rtl/core/mtbt_checker.sv
`timescale 1ns / 1ps

module mtbt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_record_kind,
    input logic [mtbt_pkg::OFS_W-1:0]    o_key_length,
    input logic                          o_has_value,
    input logic [mtbt_pkg::OFS_W-1:0]    o_value_offset,
    input logic [mtbt_pkg::OFS_W-1:0]    o_value_length,
    input logic [mtbt_pkg::COUNT_W-1:0]  o_tag_count,
    input logic [mtbt_pkg::OFS_W-1:0]    o_rest_offset,
    input logic                          o_last
);

    // End record always closes the words of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == mtbt_pkg::KIND_END |-> o_last)
        else $error("end record without last");

    // Tag records never carry an empty key, nor end-record fields
    a_tag_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == mtbt_pkg::KIND_TAG |->
            o_key_length != '0 && o_tag_count == '0 && o_rest_offset == '0)
        else $error("malformed tag record");

    // Boolean tags report no value
    a_bool_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_value |-> o_value_offset == '0 && o_value_length == '0)
        else $error("value fields set without value");

    // A tag record that is not last is followed by its end record
    a_tag_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_record_kind == mtbt_pkg::KIND_TAG && !o_last |=>
            o_valid && o_record_kind == mtbt_pkg::KIND_END)
        else $error("end record missing after tag");

endmodule

bind message_tag_block_tokenizer mtbt_checker u_mtbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_record_kind  (o_record_kind),
    .o_key_length   (o_key_length),
    .o_has_value    (o_has_value),
    .o_value_offset (o_value_offset),
    .o_value_length (o_value_length),
    .o_tag_count    (o_tag_count),
    .o_rest_offset  (o_rest_offset),
    .o_last         (o_last)
);

>>> tb/sv/message_tag_block_tokenizer_tb.sv
`timescale 1ns / 1ps

module message_tag_block_tokenizer_tb;

    localparam int MAX_TAGS   = 16;
    localparam int LINE_BYTES = 8192;
    localparam int OFS_W      = mtbt_pkg::OFS_W;
    localparam int INDEX_W    = mtbt_pkg::INDEX_W;
    localparam int COUNT_W    = mtbt_pkg::COUNT_W;
    localparam logic [OFS_W-1:0] LAST_POS = OFS_W'(LINE_BYTES - 1);

    typedef enum logic [1:0] {PM_DONE, PM_KEY, PM_VALUE, PM_SKIP} t_parse_mode;

    // One line byte waiting to be sent
    typedef struct {
        logic [7:0] value;
        logic       start;
        bit         hold;
        bit         calm;
    } t_feed;

    // One output word as the block should produce it
    typedef struct {
        logic               kind;
        logic [INDEX_W-1:0] slot;
        logic [OFS_W-1:0]   key_ofs;
        logic [OFS_W-1:0]   key_size;
        logic               has_val;
        logic [OFS_W-1:0]   val_ofs;
        logic [OFS_W-1:0]   val_size;
        logic [COUNT_W-1:0] count;
        logic [OFS_W-1:0]   rest;
        logic               last;
    } t_tag_rec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_byte_value = 8'h00;
    logic               i_first = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_record_kind;
    logic [INDEX_W-1:0] o_tag_index;
    logic [OFS_W-1:0]   o_key_offset;
    logic [OFS_W-1:0]   o_key_length;
    logic               o_has_value;
    logic [OFS_W-1:0]   o_value_offset;
    logic [OFS_W-1:0]   o_value_length;
    logic [COUNT_W-1:0] o_tag_count;
    logic [OFS_W-1:0]   o_rest_offset;
    logic               o_last;

    // Parser state mirrored by the predictor
    t_parse_mode        pmode = PM_DONE;
    logic [OFS_W-1:0]   cur_pos = '0;
    logic [OFS_W-1:0]   seg_start = '0;
    logic [OFS_W-1:0]   key_span = '0;
    logic [OFS_W-1:0]   val_begin = '0;
    logic               val_seen = 1'b0;
    logic [COUNT_W-1:0] tags_stored = '0;

    t_feed    byte_feed[$];
    t_tag_rec awaited_records[$];
    t_feed    next_word;

    bit in_fire = 1'b0;
    bit idle_ok = 1'b1;
    bit gen_calm = 1'b0;
    bit gen_hold = 1'b0;
    int send_gap = 0;
    int take_gap = 0;

    int mismatch_count = 0;
    int bytes_taken = 0;
    int blocks_started = 0;
    int tag_records_seen = 0;
    int end_records_seen = 0;
    int overflow_drops = 0;
    int drain_pauses = 0;

    message_tag_block_tokenizer #(
        .MAX_TAGS   (MAX_TAGS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_value   (i_byte_value),
        .i_first        (i_first),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_kind  (o_record_kind),
        .o_tag_index    (o_tag_index),
        .o_key_offset   (o_key_offset),
        .o_key_length   (o_key_length),
        .o_has_value    (o_has_value),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length),
        .o_tag_count    (o_tag_count),
        .o_rest_offset  (o_rest_offset),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // position counter sticks at the last line offset
    function automatic logic [OFS_W-1:0] step_pos(logic [OFS_W-1:0] p);
        return (p == LAST_POS) ? LAST_POS : p + 1'b1;
    endfunction

    function automatic void open_segment(logic [OFS_W-1:0] start);
        seg_start = start;
        key_span  = '0;
        val_begin = '0;
        val_seen  = 1'b0;
    endfunction

    // close the tag in progress at offset p; 1 if it yields a record
    function automatic bit close_tag(logic [OFS_W-1:0] p, output t_tag_rec rec);
        logic [OFS_W-1:0] klen;
        rec  = '{default: '0};
        klen = val_seen ? key_span : p - seg_start;
        if (klen == '0)
            return 1'b0;
        if (tags_stored >= MAX_TAGS) begin
            overflow_drops++;
            return 1'b0;
        end
        rec.kind     = mtbt_pkg::KIND_TAG;
        rec.slot     = tags_stored[INDEX_W-1:0];
        rec.key_ofs  = seg_start;
        rec.key_size = klen;
        if (val_seen) begin
            rec.has_val  = 1'b1;
            rec.val_ofs  = val_begin;
            rec.val_size = p - val_begin;
        end
        tags_stored++;
        return 1'b1;
    endfunction

    function automatic t_tag_rec end_record(logic [OFS_W-1:0] p);
        t_tag_rec rec;
        rec       = '{default: '0};
        rec.kind  = mtbt_pkg::KIND_END;
        rec.count = tags_stored;
        rec.rest  = p;
        pmode     = PM_DONE;
        return rec;
    endfunction

    // advance the parser by one accepted byte and queue what it yields
    function automatic void tokenize_byte(logic [7:0] b, logic start);
        t_tag_rec         recs[2];
        int               n;
        int               i;
        logic [OFS_W-1:0] p;
        n = 0;
        if (start) begin
            pmode       = PM_KEY;
            cur_pos     = '0;
            tags_stored = '0;
            open_segment('0);
            blocks_started++;
        end
        if (pmode == PM_DONE)
            return;
        p = cur_pos;
        if (pmode == PM_SKIP) begin
            if (b != mtbt_pkg::CHAR_SPACE) begin
                recs[0] = end_record(p);
                n = 1;
            end
        end else if (b == mtbt_pkg::CHAR_NUL) begin
            if (close_tag(p, recs[0]))
                n = 1;
            recs[n] = end_record(p);
            n++;
        end else if (b == mtbt_pkg::CHAR_SPACE) begin
            if (close_tag(p, recs[0]))
                n = 1;
            pmode = PM_SKIP;
        end else if (b == mtbt_pkg::CHAR_SEMI) begin
            if (close_tag(p, recs[0]))
                n = 1;
            pmode = PM_KEY;
            open_segment(step_pos(p));
        end else if (b == mtbt_pkg::CHAR_EQ && pmode == PM_KEY) begin
            key_span  = p - seg_start;
            val_begin = step_pos(p);
            val_seen  = 1'b1;
            pmode     = PM_VALUE;
        end
        if (n > 0)
            recs[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            awaited_records.push_back(recs[i]);
        cur_pos = step_pos(p);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [OFS_W-1:0] want,
                               logic [OFS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_record();
        t_tag_rec want;
        if (awaited_records.size() == 0) begin
            $error("record word with nothing expected: kind %0d", o_record_kind);
            mismatch_count++;
        end else begin
            want = awaited_records.pop_front();
            check_field("record_kind", OFS_W'(want.kind), OFS_W'(o_record_kind));
            check_field("tag_index", OFS_W'(want.slot), OFS_W'(o_tag_index));
            check_field("key_offset", want.key_ofs, o_key_offset);
            check_field("key_length", want.key_size, o_key_length);
            check_field("has_value", OFS_W'(want.has_val), OFS_W'(o_has_value));
            check_field("value_offset", want.val_ofs, o_value_offset);
            check_field("value_length", want.val_size, o_value_length);
            check_field("tag_count", OFS_W'(want.count), OFS_W'(o_tag_count));
            check_field("rest_offset", want.rest, o_rest_offset);
            check_field("last", OFS_W'(want.last), OFS_W'(o_last));
            if (want.kind == mtbt_pkg::KIND_TAG)
                tag_records_seen++;
            else
                end_records_seen++;
        end
    endtask

    // monitor: outputs first, then the byte taken at this edge
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready)
            check_record();
        if (in_fire) begin
            tokenize_byte(i_byte_value, i_first);
            bytes_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: sender and receiver, both change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            // sender: a word stays put until it is taken
            if (!i_valid || in_fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (byte_feed.size() == 0 ||
                             (byte_feed[0].hold && awaited_records.size() != 0)) begin
                    i_valid <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    i_valid <= 1'b0;
                end else begin
                    next_word = byte_feed.pop_front();
                    idle_ok = !next_word.calm;
                    i_valid <= 1'b1;
                    i_byte_value <= next_word.value;
                    i_first <= next_word.start;
                end
            end
            // receiver stalls in bursts
            if (take_gap > 0) begin
                take_gap--;
                i_ready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(0, 15);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_byte(logic [7:0] v, logic start);
        t_feed w;
        w.value = v;
        w.start = start;
        w.hold  = gen_hold;
        w.calm  = gen_calm;
        if (gen_hold)
            drain_pauses++;
        gen_hold = 1'b0;
        byte_feed.push_back(w);
    endtask

    task automatic push_text(string s, logic start);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], start && i == 0);
    endtask

    // a key or value byte that does not end the tag
    function automatic logic [7:0] plain_char(bit allow_eq);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == mtbt_pkg::CHAR_SPACE || c == mtbt_pkg::CHAR_SEMI ||
               (!allow_eq && c == mtbt_pkg::CHAR_EQ));
        return c;
    endfunction

    function automatic logic [7:0] non_space();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == mtbt_pkg::CHAR_SPACE);
        return c;
    endfunction

    // one random tag block, mostly well formed; returns the bytes that count
    task automatic gen_block(output int made);
        logic [7:0] text[$];
        int         ntags;
        int         klen;
        int         vlen;
        int         t;
        int         i;
        bit         cut;
        ntags = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        cut   = ($urandom_range(0, 9) == 0);
        for (t = 0; t < ntags; t++) begin
            klen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            repeat (klen) text.push_back(plain_char(1'b0));
            if ($urandom_range(0, 2) != 0) begin
                text.push_back(mtbt_pkg::CHAR_EQ);
                vlen = $urandom_range(0, 5);
                for (i = 0; i < vlen; i++)
                    text.push_back(($urandom_range(0, 5) == 0) ? mtbt_pkg::CHAR_EQ
                                                               : plain_char(1'b1));
            end
            if (t != ntags - 1 || $urandom_range(0, 5) == 0)
                text.push_back(mtbt_pkg::CHAR_SEMI);
        end
        // block end, unless the next start cuts it short
        if (!cut) begin
            if ($urandom_range(0, 3) == 0) begin
                text.push_back(mtbt_pkg::CHAR_NUL);
            end else begin
                repeat ($urandom_range(1, 3)) text.push_back(mtbt_pkg::CHAR_SPACE);
                text.push_back(($urandom_range(0, 3) == 0) ? mtbt_pkg::CHAR_NUL
                                                           : non_space());
            end
        end
        if (text.size() == 0)
            text.push_back(mtbt_pkg::CHAR_NUL);
        for (i = 0; i < text.size(); i++)
            push_byte(text[i], i == 0);
        made = text.size();
        // leftovers of the line, ignored until the next start unless the block was cut
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        // stray words, now and then with a start flag
        if ($urandom_range(0, 5) == 0)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int made;
        int total;
        int blk;

        // directed: ignored before any start, empty keys, boolean tag,
        // second '=', trailing spaces, NUL closing a value, empty block
        push_text("z", 1'b0);
        push_byte(mtbt_pkg::CHAR_NUL, 1'b0);
        push_text("a=1;;=v;b;c=x=y", 1'b1);
        push_byte(8'hFF, 1'b0);
        push_text("  d", 1'b0);
        push_text("e", 1'b0);
        push_text("k=", 1'b1);
        push_byte(mtbt_pkg::CHAR_NUL, 1'b0);
        push_text(";", 1'b1);
        push_byte(mtbt_pkg::CHAR_NUL, 1'b0);

        // random blocks; pauses for a full drain now and then
        total = 0;
        blk = 0;
        while (total < 800) begin
            gen_calm = (total >= 250 && total < 400) || total >= 650;
            gen_hold = (blk % 12 == 0);
            gen_block(made);
            total += made;
            blk++;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || i_valid)
            @(posedge i_clk);
        while (awaited_records.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d bytes in %0d tag blocks: %0d tag and %0d end records checked",
                 bytes_taken, blocks_started, tag_records_seen, end_records_seen);
        $display("%0d tags dropped at the tag limit, %0d full drain pauses",
                 overflow_drops, drain_pauses);
        if (mismatch_count == 0 && awaited_records.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
